// ===== src/asn1_time_to_epoch_seconds_defines.svh =====
// assertion macros used by the asn1 time converter back end
`ifndef ASN1_TIME_TO_EPOCH_SECONDS_DEFINES_SVH
`define ASN1_TIME_TO_EPOCH_SECONDS_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASN1T_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("asn1t assertion failed");
// next-cycle implication
`define ASN1T_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("asn1t assertion failed");
`else
`define ASN1T_ASSERT_IMP(label, clk, rst_n, pre, post)
`define ASN1T_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== src/asn1t_pkg.sv =====
// shared types, constants and tables of the asn1 time converter
package asn1t_pkg;

	// time kind codes
	localparam logic [1:0] KIND_UTC = 2'd0;
	localparam logic [1:0] KIND_GEN = 2'd1;

	// ascii codes
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_Z    = 8'h5A;

	// form geometry
	localparam logic [4:0] UTC_DIGITS = 5'd12;
	localparam logic [4:0] GEN_DIGITS = 5'd14;
	localparam logic [4:0] UTC_YLEN   = 5'd2;
	localparam logic [4:0] GEN_YLEN   = 5'd4;
	localparam logic [4:0] POS_MAX    = 5'd16;

	// year mapping and limits
	localparam logic [13:0] YEAR_PIVOT  = 14'd50;
	localparam logic [13:0] YEAR_1900   = 14'd1900;
	localparam logic [13:0] YEAR_2000   = 14'd2000;
	localparam logic [13:0] YEAR_MIN    = 14'd1970;

	// field codes within the date and time digits
	localparam logic [2:0] FLD_MONTH  = 3'd0;
	localparam logic [2:0] FLD_DAY    = 3'd1;
	localparam logic [2:0] FLD_HOUR   = 3'd2;
	localparam logic [2:0] FLD_MINUTE = 3'd3;

	// one parsed string handed from front to back
	typedef struct packed {
		logic        ok;
		logic        utc;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} rec_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// days before the shifted month, march first as month zero
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/asn1t_front.sv =====
// character front end: position tracking, digit accumulation and format checks
module asn1t_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_kind,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	input  asn1t_pkg::qstat_t qstat,
	output logic              push,
	output asn1t_pkg::rec_t   push_rec
);

	logic [4:0]  pos_q;
	logic [1:0]  kind_q;
	logic        bad_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;

	logic        accept;
	logic [1:0]  kind_eff;
	logic [4:0]  ndig, ylen, pdiff;
	logic [2:0]  fsel;
	logic        is_digit, len_ok;
	logic [3:0]  digit;
	logic [17:0] year_mul;
	logic [10:0] two_mul;
	logic [6:0]  two_src;
	logic        bad_n;
	logic [13:0] year_n;
	logic [6:0]  month_n, day_n, hour_n, minute_n, second_n;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_last;

	// kind is sampled on the first character
	assign kind_eff = (pos_q == 5'd0) ? in_kind : kind_q;
	assign ndig = (kind_eff == asn1t_pkg::KIND_UTC) ? asn1t_pkg::UTC_DIGITS
		: asn1t_pkg::GEN_DIGITS;
	assign ylen = (kind_eff == asn1t_pkg::KIND_UTC) ? asn1t_pkg::UTC_YLEN
		: asn1t_pkg::GEN_YLEN;
	assign pdiff = pos_q - ylen;
	assign fsel  = pdiff[3:1];

	assign is_digit = (in_char >= asn1t_pkg::CHAR_ZERO) && (in_char <= asn1t_pkg::CHAR_NINE);
	assign digit    = 4'(in_char - asn1t_pkg::CHAR_ZERO);

	// multiply-by-ten accumulators
	assign year_mul = 18'(year_q) * 18'd10 + 18'(digit);
	always_comb begin
		case (fsel)
			asn1t_pkg::FLD_MONTH:  two_src = month_q;
			asn1t_pkg::FLD_DAY:    two_src = day_q;
			asn1t_pkg::FLD_HOUR:   two_src = hour_q;
			asn1t_pkg::FLD_MINUTE: two_src = minute_q;
			default:               two_src = second_q;
		endcase
	end
	assign two_mul = 11'(two_src) * 11'd10 + 11'(digit);

	// next field values and format flag
	always_comb begin
		bad_n    = bad_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		if ((kind_eff != asn1t_pkg::KIND_UTC) && (kind_eff != asn1t_pkg::KIND_GEN)) begin
			bad_n = 1'b1;
		end else if (pos_q < ndig) begin
			if (!is_digit) begin
				bad_n = 1'b1;
			end else if (pos_q < ylen) begin
				year_n = year_mul[13:0];
			end else begin
				case (fsel)
					asn1t_pkg::FLD_MONTH:  month_n  = two_mul[6:0];
					asn1t_pkg::FLD_DAY:    day_n    = two_mul[6:0];
					asn1t_pkg::FLD_HOUR:   hour_n   = two_mul[6:0];
					asn1t_pkg::FLD_MINUTE: minute_n = two_mul[6:0];
					default:               second_n = two_mul[6:0];
				endcase
			end
		end else if (pos_q == ndig) begin
			if (in_char != asn1t_pkg::CHAR_Z) begin
				bad_n = 1'b1;
			end
		end else begin
			bad_n = 1'b1;
		end
	end

	// length must land exactly on the 'Z'
	assign len_ok = (pos_q == ndig);

	// record pushed on the last character
	always_comb begin
		push_rec.ok     = !bad_n && len_ok && ((kind_eff == asn1t_pkg::KIND_UTC)
			|| (kind_eff == asn1t_pkg::KIND_GEN));
		push_rec.utc    = (kind_eff == asn1t_pkg::KIND_UTC);
		push_rec.year   = year_n;
		push_rec.month  = month_n;
		push_rec.day    = day_n;
		push_rec.hour   = hour_n;
		push_rec.minute = minute_n;
		push_rec.second = second_n;
	end

	// parse state, cleared at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			kind_q   <= '0;
			bad_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q    <= '0;
				kind_q   <= '0;
				bad_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				if (pos_q < asn1t_pkg::POS_MAX) begin
					pos_q <= pos_q + 5'd1;
				end
				kind_q   <= kind_eff;
				bad_q    <= bad_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
			end
		end
	end

endmodule

// ===== src/asn1t_fifo.sv =====
// two-entry queue of parsed records between front and back
module asn1t_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  asn1t_pkg::rec_t   push_rec,
	input  logic              pop,
	output asn1t_pkg::rec_t   pop_rec,
	output asn1t_pkg::qstat_t qstat
);

	asn1t_pkg::rec_t mem_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign pop_rec     = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/asn1t_back.sv =====
// date back end: range checks and sequenced conversion to epoch seconds
`include "asn1_time_to_epoch_seconds_defines.svh"
module asn1t_back (
	input  logic              clk,
	input  logic              arst_n,
	input  asn1t_pkg::qstat_t qstat,
	input  asn1t_pkg::rec_t   pop_rec,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_res_ok,
	output logic [37:0]       out_seconds
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YEAR,
		ST_CHECK,
		ST_ERA,
		ST_YOE,
		ST_DOE,
		ST_DAYS,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} state_t;

	state_t          state_q;
	asn1t_pkg::rec_t rec_q;
	logic [13:0]     year_q, yadj_q;
	logic            ok_q;
	logic [3:0]      mp_q;
	logic [5:0]      era_q;
	logic [8:0]      yoe_q;
	logic [17:0]     doe_q;
	logic [22:0]     days_q;
	logic [37:0]     daysec_q;
	logic [16:0]     tod_q;
	logic [37:0]     secs_q;

	logic [13:0] year_full;
	logic        range_ok;
	logic [27:0] era_prod;
	logic [14:0] yoe_full;
	logic [1:0]  cent;
	logic [17:0] doe_n;
	logic [23:0] days_n;
	logic [39:0] daysec_n;
	logic [16:0] tod_n;
	logic        out_free;

	assign pop      = (state_q == ST_IDLE) && !qstat.empty;
	assign out_free = !out_valid || out_ready;

	// two-digit years pivot at fifty
	always_comb begin
		if (!rec_q.utc) begin
			year_full = rec_q.year;
		end else if (rec_q.year >= asn1t_pkg::YEAR_PIVOT) begin
			year_full = rec_q.year + asn1t_pkg::YEAR_1900;
		end else begin
			year_full = rec_q.year + asn1t_pkg::YEAR_2000;
		end
	end

	assign range_ok = (year_q >= asn1t_pkg::YEAR_MIN)
		&& (rec_q.month >= 7'd1) && (rec_q.month <= 7'd12)
		&& (rec_q.day >= 7'd1) && (rec_q.day <= 7'd31)
		&& (rec_q.hour <= 7'd23) && (rec_q.minute <= 7'd59)
		&& (rec_q.second <= 7'd60);

	// year / 400 by reciprocal, exact for all 14-bit years
	assign era_prod = 28'(yadj_q) * 28'd10486;
	assign yoe_full = 15'(yadj_q) - 15'(era_q) * 15'd400;

	// yoe / 100 for yoe below 400
	always_comb begin
		if (yoe_q >= 9'd300) begin
			cent = 2'd3;
		end else if (yoe_q >= 9'd200) begin
			cent = 2'd2;
		end else if (yoe_q >= 9'd100) begin
			cent = 2'd1;
		end else begin
			cent = 2'd0;
		end
	end

	assign doe_n = 18'(yoe_q) * 18'd365 + 18'(yoe_q[8:2]) - 18'(cent)
		+ 18'(asn1t_pkg::month_offset(mp_q)) + 18'(rec_q.day) - 18'd1;
	assign days_n   = 24'(era_q) * 24'd146097 + 24'(doe_q) - 24'd719468;
	assign daysec_n = 40'(days_q) * 40'd86400;
	assign tod_n    = 17'(rec_q.hour) * 17'd3600 + 17'(rec_q.minute) * 17'd60
		+ 17'(rec_q.second);

	// datapath registers, one step per state
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					rec_q <= pop_rec;
				end
			end
			ST_YEAR: begin
				year_q <= year_full;
			end
			ST_CHECK: begin
				ok_q   <= rec_q.ok && range_ok;
				yadj_q <= year_q - ((rec_q.month <= 7'd2) ? 14'd1 : 14'd0);
				mp_q   <= (rec_q.month > 7'd2) ? 4'(rec_q.month - 7'd3)
					: 4'(rec_q.month + 7'd9);
			end
			ST_ERA: begin
				era_q <= era_prod[27:22];
			end
			ST_YOE: begin
				yoe_q <= yoe_full[8:0];
			end
			ST_DOE: begin
				doe_q <= doe_n;
			end
			ST_DAYS: begin
				days_q <= days_n[22:0];
			end
			ST_MUL: begin
				daysec_q <= daysec_n[37:0];
				tod_q    <= tod_n;
			end
			ST_SUM: begin
				secs_q <= daysec_q + 38'(tod_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid   <= 1'b0;
			out_res_ok  <= 1'b0;
			out_seconds <= '0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_ERA;
				ST_ERA:   state_q <= ST_YOE;
				ST_YOE:   state_q <= ST_DOE;
				ST_DOE:   state_q <= ST_DAYS;
				ST_DAYS:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						out_res_ok  <= ok_q;
						out_seconds <= ok_q ? secs_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// an invalid string always reports zero seconds
	`ASN1T_ASSERT_IMP(a_invalid_zero, clk, arst_n, out_valid && !out_res_ok, out_seconds == '0)
	// valid results stay below year 10000
	`ASN1T_ASSERT_IMP(a_secs_bound, clk, arst_n, out_valid && out_res_ok,
		out_seconds <= 38'd253402300800)
	// a finished result waits while the output is stalled
	`ASN1T_ASSERT_NXT(a_done_wait, clk, arst_n, state_q == ST_DONE && out_valid && !out_ready,
		state_q == ST_DONE)
	// the queue is only drained when a record is there
	`ASN1T_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, !qstat.empty)

endmodule

// ===== src/asn1_time_to_epoch_seconds.sv =====
// asn1 time converter: utc and generalized time strings to epoch seconds
// throughput: one character per cycle while the record queue has room; the back end
//   handles one string at a time, and its work is hidden behind the at least 13
//   characters of any well formed string
// a two-entry record queue lets the front keep taking characters while a result waits
// reset: arst_n clears parse state, queue and sequencer; no result pending after reset
module asn1_time_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] character
	input  logic [1:0]  s_tuser,  // [1:0] time_kind
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [37:0] epoch_seconds, [39:38] zero
	output logic [0:0]  m_tuser   // [0] valid_res
);

	asn1t_pkg::qstat_t qstat;
	asn1t_pkg::rec_t   push_rec, pop_rec;
	logic              push, pop;
	logic              res_ok;
	logic [37:0]       seconds;

	// character parsing
	asn1t_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_char  (s_tdata),
		.in_last  (s_tlast),
		.qstat    (qstat),
		.push     (push),
		.push_rec (push_rec)
	);

	// record queue
	asn1t_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.qstat    (qstat)
	);

	// date conversion
	asn1t_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop_rec     (pop_rec),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res_ok  (res_ok),
		.out_seconds (seconds)
	);

	assign m_tdata = {2'b00, seconds};
	assign m_tuser = res_ok;

endmodule

// ===== verif/asn1_time_to_epoch_seconds_test.sv =====
// testbench for the asn1 time string to epoch seconds converter
`timescale 1ns / 100ps

module asn1_time_to_epoch_seconds_test;
	import asn1t_pkg::*;

	// kind codes the package leaves unnamed
	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int UTC_LEN = 13;
	localparam int GEN_LEN = 15;
	localparam int ITEM_TARGET = 500;
	localparam int HOLD_AFTER = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] ch;
		logic       last;
		bit         drain;
		bit         burst;
	} time_char_t;

	typedef struct packed {
		logic        ok;
		logic [37:0] secs;
	} epoch_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] character
	logic [1:0]  s_tuser = '0;   // [1:0] time_kind
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [37:0] epoch_seconds, [39:38] zero
	logic [0:0]  m_tuser;        // [0] valid_res

	time_char_t    char_q[$];
	epoch_result_t epoch_q[$];
	logic [7:0]    text[$];
	time_char_t    cur_char;

	// parse state of the predictor
	logic [1:0]  pk_kind;
	logic [4:0]  pk_pos;
	logic        pk_bad;
	logic [13:0] pk_year;
	logic [6:0]  pk_month, pk_day, pk_hour, pk_minute, pk_second;

	int err_count = 0;
	int item_total = 0;
	int string_total = 0;
	int strings_sent = 0;
	int results_done = 0;
	int chars_sent = 0;
	int valid_seen = 0;
	int got_count = 0;
	int gap_left = 0;
	int sent_now;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int mon_cycles = 0;
	int quiet_cycles = 0;

	asn1_time_to_epoch_seconds dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// proleptic gregorian days since 1970-01-01
	function automatic longint unsigned days_since_1970(input int unsigned year,
			input int unsigned month, input int unsigned day);
		int unsigned y, era, yoe, mp, doy, doe;
		y = year - ((month <= 2) ? 1 : 0);
		era = y / 400;
		yoe = y - era * 400;
		mp = (month > 2) ? month - 3 : month + 9;
		doy = (153 * mp + 2) / 5 + day - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return longint'(era) * 146097 + longint'(doe) - 719468;
	endfunction

	task automatic clear_parse();
		pk_kind = KIND_UTC;
		pk_pos = '0;
		pk_bad = 1'b0;
		pk_year = '0;
		pk_month = '0;
		pk_day = '0;
		pk_hour = '0;
		pk_minute = '0;
		pk_second = '0;
	endtask

	// advance the parse by one character, queue the converted time on the last one
	task automatic parse_char(input time_char_t c);
		int unsigned p, ndig, ylen, d, year;
		logic [2:0] fld;
		logic ok;
		longint unsigned secs;
		epoch_result_t res;
		p = pk_pos;
		if (p == 0)
			pk_kind = c.kind;
		if (pk_kind == KIND_UTC) begin
			ndig = UTC_DIGITS;
			ylen = UTC_YLEN;
		end else if (pk_kind == KIND_GEN) begin
			ndig = GEN_DIGITS;
			ylen = GEN_YLEN;
		end else begin
			ndig = 0;
			ylen = 0;
			pk_bad = 1'b1;
		end
		if (pk_kind == KIND_UTC || pk_kind == KIND_GEN) begin
			if (p < ndig) begin
				if (c.ch < CHAR_ZERO || c.ch > CHAR_NINE) begin
					pk_bad = 1'b1;
				end else begin
					d = c.ch - CHAR_ZERO;
					if (p < ylen) begin
						pk_year = 14'(pk_year * 10 + d);
					end else begin
						fld = 3'((p - ylen) / 2);
						case (fld)
							FLD_MONTH:  pk_month = 7'(pk_month * 10 + d);
							FLD_DAY:    pk_day = 7'(pk_day * 10 + d);
							FLD_HOUR:   pk_hour = 7'(pk_hour * 10 + d);
							FLD_MINUTE: pk_minute = 7'(pk_minute * 10 + d);
							default:    pk_second = 7'(pk_second * 10 + d);
						endcase
					end
				end
			end else if (p == ndig) begin
				if (c.ch != CHAR_Z)
					pk_bad = 1'b1;
			end else begin
				pk_bad = 1'b1;
			end
		end
		if (p < POS_MAX)
			pk_pos = 5'(p + 1);
		if (!c.last)
			return;

		// end of string: check limits and convert
		ok = !pk_bad && (pk_kind == KIND_UTC || pk_kind == KIND_GEN) &&
			(p + 1 == ((pk_kind == KIND_UTC) ? UTC_LEN : GEN_LEN));
		year = pk_year;
		if (ok && pk_kind == KIND_UTC)
			year = (pk_year >= YEAR_PIVOT) ? YEAR_1900 + pk_year : YEAR_2000 + pk_year;
		if (ok && (year < YEAR_MIN || pk_month < 1 || pk_month > 12 || pk_day < 1 ||
				pk_day > 31 || pk_hour > 23 || pk_minute > 59 || pk_second > 60))
			ok = 1'b0;
		secs = 0;
		if (ok)
			secs = days_since_1970(year, pk_month, pk_day) * 86400 +
				longint'(pk_hour) * 3600 + longint'(pk_minute) * 60 + longint'(pk_second);
		res.ok = ok;
		res.secs = 38'(secs);
		epoch_q.push_back(res);
		clear_parse();
	endtask

	// stimulus helpers
	task automatic put_num(input int unsigned value, input int ndig);
		int unsigned div;
		div = 1;
		for (int i = 1; i < ndig; i++)
			div = div * 10;
		for (int i = 0; i < ndig; i++) begin
			text.push_back(8'(CHAR_ZERO + (value / div) % 10));
			div = div / 10;
		end
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endtask

	function automatic int pick_field(input int lo, input int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(lo, hi);
		else if (r < 86)
			return lo;
		else if (r < 92)
			return hi;
		else if (r < 96)
			return hi + 1;
		return $urandom_range(0, 99);
	endfunction

	// a well formed string with random field values
	task automatic build_time(input logic [1:0] kind);
		int r;
		if (kind == KIND_UTC) begin
			put_num($urandom_range(0, 99), 2);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70)
				put_num($urandom_range(1970, 2100), 4);
			else if (r < 80)
				put_num($urandom_range(1969, 1970), 4);
			else if (r < 90)
				put_num($urandom_range(0, 9999), 4);
			else
				put_num(9999, 4);
		end
		put_num(pick_field(1, 12), 2);
		put_num(pick_field(1, 31), 2);
		put_num(pick_field(0, 23), 2);
		put_num(pick_field(0, 59), 2);
		put_num(pick_field(0, 60), 2);
		text.push_back(CHAR_Z);
	endtask

	// later characters carry random kind codes, which the block must ignore
	task automatic push_string(input logic [1:0] kind, input bit drain);
		time_char_t c;
		bit burst;
		burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < text.size(); i++) begin
			c.kind = (i == 0) ? kind : 2'($urandom_range(0, 3));
			c.ch = text[i];
			c.last = (i == text.size() - 1);
			c.drain = drain && (i == 0);
			c.burst = burst;
			char_q.push_back(c);
		end
		item_total += text.size();
		string_total++;
		text.delete();
	endtask

	task automatic make_random_string(input bit drain);
		logic [1:0] kind;
		int n;
		kind = 2'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 70) begin
			build_time(kind);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					// other kind with a plausible body or noise
					kind = 2'($urandom_range(KIND_OTHER, KIND_SPARE));
					if ($urandom_range(0, 1)) begin
						build_time(2'($urandom_range(0, 1)));
					end else begin
						n = $urandom_range(1, 18);
						repeat (n) text.push_back(8'($urandom_range(0, 255)));
					end
				end
				1: begin
					// random byte where a digit belongs
					build_time(kind);
					text[$urandom_range(0, text.size() - 2)] = 8'($urandom_range(0, 255));
				end
				2: begin
					// random byte in place of the Z
					build_time(kind);
					text[text.size() - 1] = 8'($urandom_range(0, 255));
				end
				default: begin
					// short or long string
					build_time(kind);
					if ($urandom_range(0, 1)) begin
						n = $urandom_range(1, text.size() - 1);
						while (text.size() > n)
							void'(text.pop_back());
					end else begin
						n = $urandom_range(1, 6);
						repeat (n) text.push_back(8'($urandom_range(0, 255)));
					end
				end
			endcase
		end
		push_string(kind, drain);
	endtask

	// sender: offers queued characters, feeds each transfer into the predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
			strings_sent <= 0;
			gap_left = 0;
			clear_parse();
		end else begin
			sent_now = strings_sent;
			if (s_tvalid && s_tready) begin
				parse_char(cur_char);
				chars_sent <= chars_sent + 1;
				if (cur_char.last)
					sent_now++;
				strings_sent <= sent_now;
			end
			if (s_tvalid && !s_tready) begin
				// keep offering the same character
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (char_q.size() == 0 || (char_q[0].drain && results_done != sent_now)) begin
				s_tvalid <= 1'b0;
			end else begin
				cur_char = char_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= cur_char.ch;
				s_tuser <= cur_char.kind;
				s_tlast <= cur_char.last;
				gap_left = cur_char.burst ? 0 : pick_gap();
			end
		end
	end

	// receiver: compares each result transfer, stalls at random and once for long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			results_done <= 0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			mon_cycles++;
			if (m_tvalid && m_tready) begin
				if (epoch_q.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[37:0], 0);
				end else begin
					if (m_tuser[0] !== epoch_q[0].ok)
						report_mismatch("valid_res", m_tuser[0], epoch_q[0].ok);
					if (m_tdata[37:0] !== epoch_q[0].secs)
						report_mismatch("epoch_seconds", m_tdata[37:0], epoch_q[0].secs);
					if (m_tdata[39:38] !== 2'b00)
						report_mismatch("tdata pad bits", m_tdata[39:38], 0);
					void'(epoch_q.pop_front());
				end
				if (m_tuser[0] === 1'b1)
					valid_seen++;
				results_done <= results_done + 1;
				got_count++;
				if (got_count == HOLD_AFTER && !hold_done) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (mon_cycles % 600 >= 150)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("timeout after %0d quiet cycles", quiet_cycles);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		// directed: extreme utc time with leap second, epoch zero, other kinds, short string
		put_text("491231235960Z");
		push_string(KIND_UTC, 0);
		put_text("19700101000000Z");
		push_string(KIND_GEN, 0);
		text.push_back(CHAR_Z);
		push_string(KIND_OTHER, 0);
		text.push_back(8'hFF);
		push_string(KIND_SPARE, 0);
		text.push_back(CHAR_Z);
		push_string(KIND_UTC, 0);

		// random strings, now and then waiting for the converter to drain
		while (item_total < ITEM_TARGET)
			make_random_string(string_total % 15 == 7);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (char_q.size() != 0 || s_tvalid || results_done != strings_sent);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (epoch_q.size() != 0)
			report_mismatch("results never delivered", 0, epoch_q.size());

		$display("sent %0d characters in %0d strings, %0d results with %0d valid times",
			chars_sent, strings_sent, got_count, valid_seen);
		$display("included a long receiver hold and drained pauses on the input side");
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
